>>> rtl/core/ncl_pkg.sv
package ncl_pkg;

  localparam int unsigned NclEntries = 32;

  typedef enum logic [1:0] {
    ST_HIT          = 2'd0,
    ST_MISS         = 2'd1,
    ST_UPDATED      = 2'd2,
    ST_NEW_OR_IGNORED = 2'd3
  } ncl_status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_COMMIT,
    FSM_OUT
  } ncl_state_e;

  typedef struct packed {
    logic        func;
    logic [7:0]  if_index;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [47:0] new_mac;
  } ncl_req_t;

  typedef struct packed {
    ncl_status_e status;
    logic        new_slot;
    logic [47:0] found_mac;
  } ncl_rsp_t;

  typedef struct packed {
    logic [7:0]  iface;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [47:0] mac;
  } ncl_entry_t;

  localparam int unsigned NclEntryWidth = $bits(ncl_entry_t);

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } ncl_cmd_t;

  typedef struct packed {
    logic hit;
    logic last;
  } ncl_sts_t;

endpackage

>>> rtl/core/ncl_ram.sv
module ncl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/ncl_ctrl.sv
module ncl_ctrl
  import ncl_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  ncl_sts_t sts_i,
  output ncl_cmd_t cmd_o
);

  ncl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      FSM_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = FSM_SCAN;
        end
      end
      FSM_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.hit || sts_i.last) begin
          state_d = FSM_COMMIT;
        end
      end
      FSM_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = FSM_OUT;
      end
      FSM_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // first match ends the scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_SCAN && sts_i.hit) |=> state_q == FSM_COMMIT)
    else $error("scan did not stop on hit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while result pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == FSM_COMMIT |=> out_valid_o)
    else $error("commit not followed by result");

endmodule

>>> rtl/core/ncl_datapath.sv
module ncl_datapath
  import ncl_pkg::*;
#(
  parameter int unsigned ENTRIES = NclEntries
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  ncl_req_t req_i,
  input  ncl_cmd_t cmd_i,
  output ncl_sts_t sts_o,
  output ncl_rsp_t rsp_o
);

  localparam int unsigned IdxW = $clog2(ENTRIES);
  localparam int unsigned CntW = $clog2(ENTRIES + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);

  ncl_req_t         req_q;
  ncl_rsp_t         rsp_q, rsp_d;
  logic [CntW-1:0]  scan_cnt_q, scan_cnt_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0]  cmp_idx_q, cmp_idx_d;
  logic             hit_q, hit_d;
  logic [IdxW-1:0]  hit_idx_q, hit_idx_d;
  logic [47:0]      hit_mac_q, hit_mac_d;
  logic [IdxW-1:0]  ptr_q, ptr_d;
  logic [ENTRIES-1:0] valid_q, valid_d;

  logic       req_zero;
  logic       issue;
  logic       match;
  logic       wr_en;
  logic       wr_new;
  logic [IdxW-1:0] wr_addr;
  ncl_entry_t wr_entry;
  ncl_entry_t rd_entry;

  assign req_zero = (req_q.addr_hi == 64'd0) && (req_q.addr_lo == 64'd0);
  assign issue    = cmd_i.scan && (scan_cnt_q < CntW'(ENTRIES));

  assign match = cmp_vld_q && valid_q[cmp_idx_q] && !req_zero &&
                 (rd_entry.iface == req_q.if_index) &&
                 (rd_entry.addr_hi == req_q.addr_hi) &&
                 (rd_entry.addr_lo == req_q.addr_lo);

  assign sts_o.hit  = cmd_i.scan && match;
  assign sts_o.last = cmd_i.scan && cmp_vld_q && (cmp_idx_q == LastIdx);

  assign wr_en   = cmd_i.commit && req_q.func && !req_zero;
  assign wr_new  = wr_en && !hit_q;
  assign wr_addr = hit_q ? hit_idx_q : ptr_q;

  assign wr_entry.iface   = req_q.if_index;
  assign wr_entry.addr_hi = req_q.addr_hi;
  assign wr_entry.addr_lo = req_q.addr_lo;
  assign wr_entry.mac     = req_q.new_mac;

  ncl_ram #(
    .WIDTH (NclEntryWidth),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_entry),
    .re_i    (issue),
    .raddr_i (scan_cnt_q[IdxW-1:0]),
    .rdata_o (rd_entry)
  );

  always_comb begin
    scan_cnt_d = scan_cnt_q;
    cmp_vld_d  = cmp_vld_q;
    cmp_idx_d  = cmp_idx_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    hit_mac_d  = hit_mac_q;
    ptr_d      = ptr_q;
    valid_d    = valid_q;
    rsp_d      = rsp_q;

    if (cmd_i.load) begin
      scan_cnt_d = '0;
      cmp_vld_d  = 1'b0;
      hit_d      = 1'b0;
    end

    if (cmd_i.scan) begin
      cmp_vld_d = issue;
      cmp_idx_d = scan_cnt_q[IdxW-1:0];
      if (issue) begin
        scan_cnt_d = scan_cnt_q + CntW'(1);
      end
      if (match) begin
        hit_d     = 1'b1;
        hit_idx_d = cmp_idx_q;
        hit_mac_d = rd_entry.mac;
      end
    end

    if (cmd_i.commit) begin
      rsp_d.new_slot  = 1'b0;
      rsp_d.found_mac = '0;
      if (!req_q.func) begin
        rsp_d.status = hit_q ? ST_HIT : ST_MISS;
        if (hit_q) begin
          rsp_d.found_mac = hit_mac_q;
        end
      end else if (req_zero) begin
        rsp_d.status = ST_NEW_OR_IGNORED;
      end else if (hit_q) begin
        rsp_d.status = ST_UPDATED;
      end else begin
        rsp_d.status   = ST_NEW_OR_IGNORED;
        rsp_d.new_slot = 1'b1;
      end
      if (wr_new) begin
        valid_d[ptr_q] = 1'b1;
        ptr_d = (ptr_q == LastIdx) ? '0 : ptr_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_cnt_q <= '0;
      cmp_vld_q  <= 1'b0;
      hit_q      <= 1'b0;
      ptr_q      <= '0;
      valid_q    <= '0;
    end else begin
      scan_cnt_q <= scan_cnt_d;
      cmp_vld_q  <= cmp_vld_d;
      hit_q      <= hit_d;
      ptr_q      <= ptr_d;
      valid_q    <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    cmp_idx_q <= cmp_idx_d;
    hit_idx_q <= hit_idx_d;
    hit_mac_q <= hit_mac_d;
    rsp_q     <= rsp_d;
  end

  assign rsp_o = rsp_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= LastIdx)
    else $error("replacement pointer out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && !req_q.func) |=> $stable(valid_q) && $stable(ptr_q))
    else $error("lookup altered the store");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && hit_q) |=> $stable(ptr_q))
    else $error("update advanced the replacement pointer");

endmodule

>>> rtl/core/neighbor_cache_lookup_insert.sv
// A lookup scans the entries in order: the scan stops at the first matching entry
// on a hit and reads every entry on a miss.
// A new item is accepted only once the previous result has been taken; the scan reads one entry
// per cycle through the single read port of the entry RAM.
// Reset: asynchronous, active low; clears all valid bits and the replacement pointer.
module neighbor_cache_lookup_insert
  import ncl_pkg::*;
#(
  parameter int unsigned ENTRIES = NclEntries
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  ncl_req_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output ncl_rsp_t out_data_o
);

  ncl_cmd_t cmd;
  ncl_sts_t sts;

  ncl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ncl_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (in_data_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (out_data_o)
  );

endmodule
